>>> sv/mlfd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the segment lookup for the meter LCD frame decoder.
// No dependencies; every other file imports this package.
package mlfd_pkg;

	localparam int FrameLen = 14;
	localparam logic [3:0] LastIdx = 4'(FrameLen - 1);

	// over-limit digit pattern, most significant digit first
	localparam logic [6:0] OlDigit0 = 7'h00;
	localparam logic [6:0] OlDigit1 = 7'h7d;
	localparam logic [6:0] OlDigit2 = 7'h68;
	localparam logic [6:0] OlDigit3 = 7'h00;

	// prefix exponents
	localparam logic signed [5:0] ExpNano  = -6'sd9;
	localparam logic signed [5:0] ExpMicro = -6'sd6;
	localparam logic signed [5:0] ExpMilli = -6'sd3;
	localparam logic signed [5:0] ExpKilo  = 6'sd3;
	localparam logic signed [5:0] ExpMega  = 6'sd6;

	// one complete frame of segment nibbles, index 0 is the first word
	typedef struct packed {
		logic [FrameLen-1:0][3:0] nib;
	} frame_t;

	typedef struct packed {
		logic signed [14:0] reading_value;
		logic [1:0]         decimal_places;
		logic signed [5:0]  power_of_ten;
		logic               over_limit;
		logic               minus_sign;
		logic [3:0]         mode_bits;
		logic [3:0]         seg10_bits;
		logic [3:0]         seg11_bits;
		logic [3:0]         seg12_bits;
		logic [3:0]         seg13_bits;
		logic [3:0]         seg14_bits;
	} result_t;

	// seven-segment pattern to digit, unknown patterns give -1
	function automatic logic signed [4:0] seg_digit(input logic [6:0] pat);
		logic signed [4:0] d;
		unique case (pat)
			7'h7d:   d = 5'sd0;
			7'h05:   d = 5'sd1;
			7'h5b:   d = 5'sd2;
			7'h1f:   d = 5'sd3;
			7'h27:   d = 5'sd4;
			7'h3e:   d = 5'sd5;
			7'h7e:   d = 5'sd6;
			7'h15:   d = 5'sd7;
			7'h7f:   d = 5'sd8;
			7'h3f:   d = 5'sd9;
			default: d = -5'sd1;
		endcase
		return d;
	endfunction

endpackage

>>> sv/mlfd_front.sv
`timescale 1ns / 1ps
// Front end: checks the position of each received word and assembles frames.
// Depends on mlfd_pkg.
module mlfd_front import mlfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] rx_byte,
	output logic       frame_push,
	output frame_t     frame
);

	logic [3:0]                exp_q;
	logic [FrameLen-2:0][3:0]  nib_q;
	logic                      hit;

	// keep a word only when it sits at the expected position
	assign hit        = take && (rx_byte[7:4] == exp_q + 4'd1);
	assign frame_push = hit && (exp_q == LastIdx);
	assign frame.nib  = {rx_byte[3:0], nib_q};

	// advance the expected position, wrap after the last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= '0;
		end else if (hit) begin
			if (exp_q == LastIdx) begin
				exp_q <= '0;
			end else begin
				exp_q <= exp_q + 4'd1;
			end
		end
	end

	// hold the nibbles of the frame in progress
	always_ff @(posedge clk) begin
		if (hit && exp_q != LastIdx) begin
			nib_q[exp_q] <= rx_byte[3:0];
		end
	end

endmodule

>>> sv/mlfd_frame_q.sv
`timescale 1ns / 1ps
// Two-entry queue of complete frames between the front and back ends.
// Depends on mlfd_pkg.
module mlfd_frame_q import mlfd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr,
	input  frame_t wr_frame,
	output logic   full,
	output logic   rd_valid,
	input  logic   rd,
	output frame_t rd_frame
);

	frame_t     mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_frame = mem_q[rptr_q];

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= ~wptr_q;
			end
			if (rd) begin
				rptr_q <= ~rptr_q;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// store the incoming frame
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wr_frame;
		end
	end

endmodule

>>> sv/mlfd_back.sv
`timescale 1ns / 1ps
// Back end: decodes a frame into a reading and holds results in a two-entry queue.
// Depends on mlfd_pkg.
module mlfd_back import mlfd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    frame_pop,
	input  frame_t  frame,
	input  logic    pop,
	output logic    empty,
	output result_t res
);

	result_t           mem_q [2];
	logic              wptr_q;
	logic              rptr_q;
	logic [1:0]        cnt_q;
	logic              wr;
	logic              rd;
	logic [3:0][6:0]   db;
	logic signed [14:0] dig [4];
	logic signed [14:0] mant;
	logic              ol;
	logic              neg;
	logic [1:0]        dp;
	logic signed [5:0] pw;
	result_t           dec;

	// take a frame whenever the result queue has room
	assign frame_pop = in_valid && (cnt_q != 2'd2);
	assign wr        = frame_pop;
	assign rd        = pop && !empty;
	assign empty     = (cnt_q == 2'd0);
	assign res       = mem_q[rptr_q];

	// decode digits, sign, decimal point and exponent
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			db[i]  = {frame.nib[1 + 2 * i][2:0], frame.nib[2 + 2 * i]};
			dig[i] = 15'(seg_digit(db[i]));
		end
		ol = (db[0] == OlDigit0) && (db[1] == OlDigit1) &&
			(db[2] == OlDigit2) && (db[3] == OlDigit3);
		neg  = frame.nib[1][3];
		mant = dig[0] * 15'sd1000 + dig[1] * 15'sd100 + dig[2] * 15'sd10 + dig[3];
		if (frame.nib[3][3]) begin
			dp = 2'd3;
		end else if (frame.nib[5][3]) begin
			dp = 2'd2;
		end else if (frame.nib[7][3]) begin
			dp = 2'd1;
		end else begin
			dp = 2'd0;
		end
		pw = 6'sd0;
		if (frame.nib[9][2]) begin
			pw = pw + ExpNano;
		end
		if (frame.nib[9][3]) begin
			pw = pw + ExpMicro;
		end
		if (frame.nib[10][3]) begin
			pw = pw + ExpMilli;
		end
		if (frame.nib[9][1]) begin
			pw = pw + ExpKilo;
		end
		if (frame.nib[10][1]) begin
			pw = pw + ExpMega;
		end
		pw = pw - $signed({4'b0, dp});

		dec.reading_value  = ol ? 15'sd0 : (neg ? -mant : mant);
		dec.decimal_places = dp;
		dec.power_of_ten   = pw;
		dec.over_limit     = ol;
		dec.minus_sign     = neg;
		dec.mode_bits      = frame.nib[0];
		dec.seg10_bits     = frame.nib[9];
		dec.seg11_bits     = frame.nib[10];
		dec.seg12_bits     = frame.nib[11];
		dec.seg13_bits     = frame.nib[12];
		dec.seg14_bits     = frame.nib[13];
	end

	// advance result queue pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= ~wptr_q;
			end
			if (rd) begin
				rptr_q <= ~rptr_q;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// store the decoded result
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= dec;
		end
	end

endmodule

>>> sv/meter_lcd_frame_decoder_unit.sv
`timescale 1ns / 1ps
// Meter LCD frame decoder: receive words from a multimeter link, emit decoded readings.
// Input channel: push/full with rx_byte; a word is taken when push is high and full low.
// Result channel: empty/pop; the oldest reading sits on the result ports while empty is
// low and leaves on a clock edge with pop high.
// Each word carries its frame position in the upper nibble (1 to 14); a word out of
// sequence, or at position 0 or 15, is dropped without restarting the frame.
// Throughput: one word per cycle while full is low. A reading reaches the result ports
// once its frame has passed the frame queue and been decoded into the result queue (a
// frame waits in the frame queue while the result queue is full), and can then leave.
// Two frames may wait between the front and the back end and two readings in the result
// queue. When the receiver stalls, the queues fill and full rises; it falls again as soon
// as the frame queue has room.
// Reset clears the expected position and both queues; no reading is pending after it.
// Depends on mlfd_pkg, mlfd_front, mlfd_frame_q and mlfd_back.
module meter_lcd_frame_decoder_unit import mlfd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [7:0]        rx_byte,
	output logic              empty,
	input  logic              pop,
	output logic signed [14:0] reading_value,
	output logic [1:0]        decimal_places,
	output logic signed [5:0] power_of_ten,
	output logic              over_limit,
	output logic              minus_sign,
	output logic [3:0]        mode_bits,
	output logic [3:0]        seg10_bits,
	output logic [3:0]        seg11_bits,
	output logic [3:0]        seg12_bits,
	output logic [3:0]        seg13_bits,
	output logic [3:0]        seg14_bits
);

	logic    take;
	logic    frame_push;
	frame_t  frame_in;
	frame_t  frame_out;
	logic    fq_valid;
	logic    frame_pop;
	result_t res;

	assign take = push && !full;

	// assemble frames
	mlfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.rx_byte    (rx_byte),
		.frame_push (frame_push),
		.frame      (frame_in)
	);

	// queue frames between front and back
	mlfd_frame_q u_frame_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (frame_push),
		.wr_frame (frame_in),
		.full     (full),
		.rd_valid (fq_valid),
		.rd       (frame_pop),
		.rd_frame (frame_out)
	);

	// decode and buffer readings
	mlfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.frame_pop (frame_pop),
		.frame     (frame_out),
		.pop       (pop),
		.empty     (empty),
		.res       (res)
	);

	assign reading_value  = res.reading_value;
	assign decimal_places = res.decimal_places;
	assign power_of_ten   = res.power_of_ten;
	assign over_limit     = res.over_limit;
	assign minus_sign     = res.minus_sign;
	assign mode_bits      = res.mode_bits;
	assign seg10_bits     = res.seg10_bits;
	assign seg11_bits     = res.seg11_bits;
	assign seg12_bits     = res.seg12_bits;
	assign seg13_bits     = res.seg13_bits;
	assign seg14_bits     = res.seg14_bits;

endmodule
